### rtl/pcb_pkg.sv
// ----------------------------------------------------------------------------
// pcb_pkg: shared types and constants for the particle cell binning block
// Op and status codes, configuration layout, the command beat passed from
// the front end to the back end, and the result beat.
// ----------------------------------------------------------------------------
package pcb_pkg;

  // Default sizes, handed to the top level parameters
  localparam int MAX_CELLS_DEF = 4096;
  localparam int MAX_SLOTS_DEF = 32;

  // Depth of the command queue between front and back end
  localparam int Q_DEPTH = 2;

  // Configuration port address width (seven 32-bit registers)
  localparam int CFG_AW = 5;

  // Configuration reset values
  localparam logic [4:0]  CELLS_RST = 5'd1;
  localparam logic [23:0] INV_RST   = 24'd65536;
  localparam logic [5:0]  SLOTS_RST = 6'd20;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CELLS_X   = 3'd0,
    REG_CELLS_Y   = 3'd1,
    REG_CELLS_Z   = 3'd2,
    REG_INV_X     = 3'd3,
    REG_INV_Y     = 3'd4,
    REG_INV_Z     = 3'd5,
    REG_SLOTS     = 3'd6
  } cfg_reg_t;

  // Operation codes
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_BIN   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Configuration register set
  typedef struct packed {
    logic [4:0]  cells_x;
    logic [4:0]  cells_y;
    logic [4:0]  cells_z;
    logic [23:0] inv_len_x;
    logic [23:0] inv_len_y;
    logic [23:0] inv_len_z;
    logic [5:0]  slots_per_cell;
  } cfg_t;

  // Classified command, front end to back end
  typedef struct packed {
    op_t         op;
    status_t     status;    // preset status: ok, absent or outside
    logic [31:0] handle;
    logic [11:0] cell_idx;  // binned cell or queried cell
    logic [12:0] limit;     // number of cells summed by a query
  } cmd_t;

  // Result beat
  typedef struct packed {
    status_t     status;
    logic [11:0] cell_index;
    logic [16:0] write_slot;
    logic [31:0] handle_out;
    logic [5:0]  cell_count;
    logic [17:0] cell_start;
  } res_t;

endpackage

### rtl/pcb_front.sv
// ----------------------------------------------------------------------------
// pcb_front: input front end
// Accepts input beats, works out the linear cell index of a bin request with
// one shared 24x24 multiplier stepping over the axes, sizes the grid for a
// query, and pushes a classified command into the queue.
// ----------------------------------------------------------------------------
module pcb_front #(
  parameter int MAX_CELLS = pcb_pkg::MAX_CELLS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  // input channel
  input  logic            in_push,
  output logic            in_full,
  input  logic [1:0]      in_op,
  input  logic            in_exists,
  input  logic [31:0]     in_handle,
  input  logic [23:0]     in_pos_x,
  input  logic [23:0]     in_pos_y,
  input  logic [23:0]     in_pos_z,
  input  logic [11:0]     in_query_cell,
  // configuration and back end status
  input  pcb_pkg::cfg_t   cfg,
  input  logic            init_busy,
  // command queue
  output logic            q_push,
  output pcb_pkg::cmd_t   q_data,
  input  logic            q_full
);

  localparam logic [16:0] MAXC = 17'(MAX_CELLS);

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_MUL   = 5'b00010,
    F_GRID  = 5'b00100,
    F_LIMIT = 5'b01000,
    F_PUSH  = 5'b10000
  } fstate_t;

  function automatic logic [4:0] clamp_cells(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (v == 5'd0) r = 5'd1;
    else if (v > 5'd16) r = 5'd16;
    return r;
  endfunction

  fstate_t       state_r, state_nxt;
  logic [1:0]    ax_r, ax_nxt;
  logic [11:0]   acc_r, acc_nxt;
  logic          outside_r, outside_nxt;
  logic [15:0]   prod_hi_r, prod_hi_nxt;
  logic [9:0]    xy_r, xy_nxt;
  logic [23:0]   pos_x_r, pos_y_r, pos_z_r;
  logic [23:0]   pos_x_nxt, pos_y_nxt, pos_z_nxt;
  pcb_pkg::cmd_t cmd_r, cmd_nxt;

  logic [4:0]    lim_x, lim_y, lim_z, lim_h;
  logic [23:0]   pos_m, inv_m;
  logic [47:0]   prod;
  logic [16:0]   acc_full;
  logic [11:0]   acc_step;
  logic          q_over;
  logic [14:0]   n_full;
  logic [16:0]   grid_lim17;
  logic [12:0]   grid_lim;
  logic          q_out;
  logic          accept;

  assign lim_x = clamp_cells(cfg.cells_x);
  assign lim_y = clamp_cells(cfg.cells_y);
  assign lim_z = clamp_cells(cfg.cells_z);

  assign in_full = (state_r != F_IDLE) || init_busy;
  assign accept  = in_push && !in_full;
  assign q_push  = (state_r == F_PUSH) && !q_full;
  assign q_data  = cmd_r;

  // axis multiplier: z, then y, then x
  always_comb begin
    case (ax_r)
      2'd0: begin
        pos_m = pos_z_r;
        inv_m = cfg.inv_len_z;
      end
      2'd1: begin
        pos_m = pos_y_r;
        inv_m = cfg.inv_len_y;
      end
      default: begin
        pos_m = pos_x_r;
        inv_m = cfg.inv_len_x;
      end
    endcase
  end

  assign prod = 48'(pos_m) * 48'(inv_m);

  // Horner step on the previous axis's cell coordinate
  always_comb begin
    case (ax_r)
      2'd1:    lim_h = lim_z;
      2'd2:    lim_h = lim_y;
      default: lim_h = lim_x;
    endcase
  end

  assign q_over   = prod_hi_r >= {11'd0, lim_h};
  assign acc_full = 17'(lim_h) * 17'(acc_r) + {13'd0, prod_hi_r[3:0]};
  assign acc_step = acc_full[11:0];

  // grid size for queries, capped at the store depth
  assign n_full     = 15'(xy_r) * 15'(lim_z);
  assign grid_lim17 = ({2'd0, n_full} > MAXC) ? MAXC : {2'd0, n_full};
  assign grid_lim   = grid_lim17[12:0];
  assign q_out      = {1'b0, cmd_r.cell_idx} >= grid_lim;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    ax_nxt      = ax_r;
    acc_nxt     = acc_r;
    outside_nxt = outside_r;
    prod_hi_nxt = prod_hi_r;
    xy_nxt      = xy_r;
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    pos_z_nxt   = pos_z_r;
    cmd_nxt     = cmd_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          cmd_nxt.op       = pcb_pkg::op_t'(in_op);
          cmd_nxt.status   = pcb_pkg::ST_OK;
          cmd_nxt.handle   = in_handle;
          cmd_nxt.cell_idx = in_query_cell;
          cmd_nxt.limit    = '0;
          pos_x_nxt        = in_pos_x;
          pos_y_nxt        = in_pos_y;
          pos_z_nxt        = in_pos_z;
          case (pcb_pkg::op_t'(in_op))
            pcb_pkg::OP_BIN: begin
              if (in_exists) begin
                ax_nxt      = 2'd0;
                acc_nxt     = '0;
                outside_nxt = 1'b0;
                state_nxt   = F_MUL;
              end else begin
                cmd_nxt.status = pcb_pkg::ST_ABSENT;
                state_nxt      = F_PUSH;
              end
            end
            pcb_pkg::OP_QUERY: state_nxt = F_GRID;
            default:           state_nxt = F_PUSH;
          endcase
        end
      end
      F_MUL: begin
        prod_hi_nxt = prod[47:32];
        ax_nxt      = ax_r + 2'd1;
        if (ax_r != 2'd0) begin
          acc_nxt     = acc_step;
          outside_nxt = outside_r | q_over;
        end
        if (ax_r == 2'd3) begin
          cmd_nxt.cell_idx = acc_step;
          cmd_nxt.status   = (outside_nxt || ({5'd0, acc_step} >= MAXC)) ?
                             pcb_pkg::ST_OUTSIDE : pcb_pkg::ST_OK;
          state_nxt        = F_PUSH;
        end
      end
      F_GRID: begin
        xy_nxt    = 10'(lim_x) * 10'(lim_y);
        state_nxt = F_LIMIT;
      end
      F_LIMIT: begin
        cmd_nxt.status = q_out ? pcb_pkg::ST_OUTSIDE : pcb_pkg::ST_OK;
        cmd_nxt.limit  = q_out ? grid_lim : {1'b0, cmd_r.cell_idx};
        state_nxt      = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ax_r      <= ax_nxt;
    acc_r     <= acc_nxt;
    outside_r <= outside_nxt;
    prod_hi_r <= prod_hi_nxt;
    xy_r      <= xy_nxt;
    pos_x_r   <= pos_x_nxt;
    pos_y_r   <= pos_y_nxt;
    pos_z_r   <= pos_z_nxt;
    cmd_r     <= cmd_nxt;
  end

endmodule

### rtl/pcb_fifo.sv
// ----------------------------------------------------------------------------
// pcb_fifo: command queue
// Short queue of classified commands between the front and back end.
// ----------------------------------------------------------------------------
module pcb_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  pcb_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output pcb_pkg::cmd_t rd_data,
  output logic          empty
);

  localparam int PTR_W = (pcb_pkg::Q_DEPTH > 1) ? $clog2(pcb_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(pcb_pkg::Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(pcb_pkg::Q_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(pcb_pkg::Q_DEPTH);

  pcb_pkg::cmd_t    entry_r [pcb_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign full    = count_r == DEPTH_C;
  assign empty   = count_r == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entry_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) entry_r[wr_ptr_r] <= wr_data;
  end

endmodule

### rtl/pcb_back.sv
// ----------------------------------------------------------------------------
// pcb_back: occupancy back end
// Holds the per-cell occupancy store. Bins by read-modify-write of one count,
// clears by sweeping the store, answers queries by walking the lower cells,
// and drives the result register.
// ----------------------------------------------------------------------------
module pcb_back #(
  parameter int MAX_CELLS = pcb_pkg::MAX_CELLS_DEF,
  parameter int MAX_SLOTS = pcb_pkg::MAX_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [5:0]    cfg_slots,
  // command queue
  input  logic          q_empty,
  input  pcb_pkg::cmd_t q_data,
  output logic          q_pop,
  output logic          init_busy,
  // result channel
  output logic          res_valid,
  output pcb_pkg::res_t res,
  input  logic          res_pop
);

  localparam int AW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam logic [8:0]    MAXS = 9'(MAX_SLOTS);
  localparam logic [AW-1:0] LAST = AW'(MAX_CELLS - 1);

  typedef enum logic [6:0] {
    B_INIT  = 7'b0000001,
    B_IDLE  = 7'b0000010,
    B_CLEAR = 7'b0000100,
    B_BIN   = 7'b0001000,
    B_SUM   = 7'b0010000,
    B_QCNT  = 7'b0100000,
    B_OUT   = 7'b1000000
  } bstate_t;

  // occupancy store
  logic [CNT_W-1:0] occ_mem [MAX_CELLS];
  logic [CNT_W-1:0] rd_data_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [CNT_W-1:0] mem_wdata;

  bstate_t       state_r, state_nxt;
  pcb_pkg::cmd_t cmd_r, cmd_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic [12:0]   walk_r, walk_nxt;
  logic          pend_r, pend_nxt;
  logic [17:0]   sum_r, sum_nxt;
  logic [17:0]   base_r, base_nxt;
  pcb_pkg::res_t res_r, res_nxt;
  logic          out_valid_r;
  pcb_pkg::res_t out_r;

  logic [5:0]       slot_use;
  logic             cnt_full;
  logic [CNT_W-1:0] cnt_inc;
  logic             out_load;

  // slots per cell in use, clamped to 1..MAX_SLOTS
  assign slot_use = (cfg_slots == 6'd0) ? 6'd1 :
                    ({3'd0, cfg_slots} > MAXS) ? MAXS[5:0] : cfg_slots;

  assign cnt_full = 9'(rd_data_r) >= {3'd0, slot_use};
  assign cnt_inc  = CNT_W'(rd_data_r + 1'b1);

  assign init_busy = state_r == B_INIT;
  assign out_load  = (state_r == B_OUT) && (!out_valid_r || res_pop);
  assign res_valid = out_valid_r;
  assign res       = out_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    sweep_nxt = sweep_r;
    walk_nxt  = walk_r;
    pend_nxt  = pend_r;
    sum_nxt   = sum_r;
    base_nxt  = base_r;
    res_nxt   = res_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = sweep_r;
    mem_wdata = '0;
    mem_raddr = AW'(q_data.cell_idx);
    unique case (state_r)
      B_INIT: begin
        mem_we = 1'b1;
        if (sweep_r == LAST) state_nxt = B_IDLE;
        else sweep_nxt = sweep_r + 1'b1;
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_data;
          res_nxt = '0;
          case (q_data.op)
            pcb_pkg::OP_CLEAR: begin
              sweep_nxt = '0;
              state_nxt = B_CLEAR;
            end
            pcb_pkg::OP_BIN: begin
              res_nxt.handle_out = q_data.handle;
              if (q_data.status != pcb_pkg::ST_OK) begin
                res_nxt.status = q_data.status;
                state_nxt      = B_OUT;
              end else begin
                base_nxt  = 18'(q_data.cell_idx * slot_use);
                state_nxt = B_BIN;
              end
            end
            pcb_pkg::OP_QUERY: begin
              walk_nxt  = '0;
              pend_nxt  = 1'b0;
              sum_nxt   = '0;
              state_nxt = B_SUM;
            end
            default: state_nxt = B_OUT;
          endcase
        end
      end
      B_CLEAR: begin
        mem_we = 1'b1;
        if (sweep_r == LAST) state_nxt = B_OUT;
        else sweep_nxt = sweep_r + 1'b1;
      end
      B_BIN: begin
        res_nxt.cell_index = cmd_r.cell_idx;
        if (cnt_full) begin
          res_nxt.status     = pcb_pkg::ST_FULL;
          res_nxt.cell_count = 6'(rd_data_r);
        end else begin
          mem_we             = 1'b1;
          mem_waddr          = AW'(cmd_r.cell_idx);
          mem_wdata          = cnt_inc;
          res_nxt.write_slot = 17'(base_r + 18'(rd_data_r));
          res_nxt.cell_count = 6'(cnt_inc);
        end
        state_nxt = B_OUT;
      end
      B_SUM: begin
        // one cell read per beat, summed as the data returns
        if (pend_r) sum_nxt = sum_r + 18'(rd_data_r);
        if (walk_r < cmd_r.limit) begin
          mem_raddr = AW'(walk_r);
          walk_nxt  = walk_r + 1'b1;
          pend_nxt  = 1'b1;
        end else begin
          mem_raddr = AW'(cmd_r.cell_idx);
          pend_nxt  = 1'b0;
          state_nxt = B_QCNT;
        end
      end
      B_QCNT: begin
        res_nxt.status     = cmd_r.status;
        res_nxt.cell_index = cmd_r.cell_idx;
        res_nxt.cell_count = (cmd_r.status == pcb_pkg::ST_OUTSIDE) ? 6'd0 : 6'(rd_data_r);
        res_nxt.cell_start = sum_r;
        state_nxt          = B_OUT;
      end
      B_OUT: begin
        if (out_load) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // store access
  always_ff @(posedge clk) begin
    if (mem_we) occ_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= occ_mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_INIT;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (res_pop) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    walk_r <= walk_nxt;
    pend_r <= pend_nxt;
    sum_r  <= sum_nxt;
    base_r <= base_nxt;
    res_r  <= res_nxt;
    if (out_load) out_r <= res_r;
  end

endmodule

### rtl/particle_cell_binning.sv
// ----------------------------------------------------------------------------
// particle_cell_binning: cell-list binning with per-cell occupancy counts
// Bin: the front end steps its one multiplier over the axes and takes no new
//   beat until the command is queued (an absent particle skips the
//   multiplier); the back end then does the read-modify-write of one count.
// Query: the back end sums the lower cells, one store read a cycle.
// Clear: one store write a cycle over the whole store.
// Reset: synchronous; then a clearing pass zeroes the counts, with full held
//   high until it ends.
// ----------------------------------------------------------------------------
module particle_cell_binning #(
  parameter int MAX_CELLS = pcb_pkg::MAX_CELLS_DEF,
  parameter int MAX_SLOTS = pcb_pkg::MAX_SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [1:0]                in_op,
  input  logic                      in_exists,
  input  logic [31:0]               in_handle,
  input  logic [23:0]               in_pos_x,
  input  logic [23:0]               in_pos_y,
  input  logic [23:0]               in_pos_z,
  input  logic [11:0]               in_query_cell,
  // result channel
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [1:0]                out_status,
  output logic [11:0]               out_cell_index,
  output logic [16:0]               out_write_slot,
  output logic [31:0]               out_handle_out,
  output logic [5:0]                out_cell_count,
  output logic [17:0]               out_cell_start,
  // configuration port
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [pcb_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);

  pcb_pkg::cfg_t     cfg_r;
  pcb_pkg::cfg_reg_t reg_idx;
  logic              cfg_wr;

  logic              q_push, q_pop, q_full, q_empty;
  pcb_pkg::cmd_t     q_wdata, q_rdata;
  logic              init_busy;
  logic              res_valid;
  pcb_pkg::res_t     res;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign reg_idx    = pcb_pkg::cfg_reg_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cells_x        <= pcb_pkg::CELLS_RST;
      cfg_r.cells_y        <= pcb_pkg::CELLS_RST;
      cfg_r.cells_z        <= pcb_pkg::CELLS_RST;
      cfg_r.inv_len_x      <= pcb_pkg::INV_RST;
      cfg_r.inv_len_y      <= pcb_pkg::INV_RST;
      cfg_r.inv_len_z      <= pcb_pkg::INV_RST;
      cfg_r.slots_per_cell <= pcb_pkg::SLOTS_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        pcb_pkg::REG_CELLS_X: cfg_r.cells_x        <= cfg_pwdata[4:0];
        pcb_pkg::REG_CELLS_Y: cfg_r.cells_y        <= cfg_pwdata[4:0];
        pcb_pkg::REG_CELLS_Z: cfg_r.cells_z        <= cfg_pwdata[4:0];
        pcb_pkg::REG_INV_X:   cfg_r.inv_len_x      <= cfg_pwdata[23:0];
        pcb_pkg::REG_INV_Y:   cfg_r.inv_len_y      <= cfg_pwdata[23:0];
        pcb_pkg::REG_INV_Z:   cfg_r.inv_len_z      <= cfg_pwdata[23:0];
        pcb_pkg::REG_SLOTS:   cfg_r.slots_per_cell <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      pcb_pkg::REG_CELLS_X: cfg_prdata = 32'(cfg_r.cells_x);
      pcb_pkg::REG_CELLS_Y: cfg_prdata = 32'(cfg_r.cells_y);
      pcb_pkg::REG_CELLS_Z: cfg_prdata = 32'(cfg_r.cells_z);
      pcb_pkg::REG_INV_X:   cfg_prdata = 32'(cfg_r.inv_len_x);
      pcb_pkg::REG_INV_Y:   cfg_prdata = 32'(cfg_r.inv_len_y);
      pcb_pkg::REG_INV_Z:   cfg_prdata = 32'(cfg_r.inv_len_z);
      pcb_pkg::REG_SLOTS:   cfg_prdata = 32'(cfg_r.slots_per_cell);
      default:              cfg_prdata = '0;
    endcase
  end

  // front end: accept and classify
  pcb_front #(
    .MAX_CELLS (MAX_CELLS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_op         (in_op),
    .in_exists     (in_exists),
    .in_handle     (in_handle),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_query_cell (in_query_cell),
    .cfg           (cfg_r),
    .init_busy     (init_busy),
    .q_push        (q_push),
    .q_data        (q_wdata),
    .q_full        (q_full)
  );

  // command queue
  pcb_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // back end: occupancy store and results
  pcb_back #(
    .MAX_CELLS (MAX_CELLS),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_slots (cfg_r.slots_per_cell),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (out_pop)
  );

  // result ports
  assign out_empty      = !res_valid;
  assign out_status     = res.status;
  assign out_cell_index = res.cell_index;
  assign out_write_slot = res.write_slot;
  assign out_handle_out = res.handle_out;
  assign out_cell_count = res.cell_count;
  assign out_cell_start = res.cell_start;

endmodule

### tb/pcb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcb_checker: result checker for the particle cell binning block
// Watches the input, result and configuration ports. It keeps its own copy of
// the grid setup and of the per-cell counts, works out each result beat when
// an input beat is taken, and compares every result beat field by field
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pcb_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_push,
  input  logic                       in_full,
  input  logic [1:0]                 in_op,
  input  logic                       in_exists,
  input  logic [31:0]                in_handle,
  input  logic [23:0]                in_pos_x,
  input  logic [23:0]                in_pos_y,
  input  logic [23:0]                in_pos_z,
  input  logic [11:0]                in_query_cell,
  // result channel
  input  logic                       out_empty,
  input  logic                       out_pop,
  input  logic [1:0]                 out_status,
  input  logic [11:0]                out_cell_index,
  input  logic [16:0]                out_write_slot,
  input  logic [31:0]                out_handle_out,
  input  logic [5:0]                 out_cell_count,
  input  logic [17:0]                out_cell_start,
  // configuration port
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [pcb_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  input  logic                       cfg_pready,
  // verdict
  output int                         mismatches,
  output int                         outstanding
);

  import pcb_pkg::*;

  localparam int NCELL_MAX = MAX_CELLS_DEF;
  localparam int NSLOT_MAX = MAX_SLOTS_DEF;

  // Shadow of the counts and of the grid setup
  logic [5:0]  occ_count [NCELL_MAX];
  logic [4:0]  grid_reg [3];
  logic [23:0] inv_reg [3];
  logic [5:0]  slots_reg;

  // Predicted result beats, oldest first
  res_t outcome_q [$];
  res_t head;

  // Cells along one axis, register clamped to 1..16
  function automatic int unsigned axis_cells(input int a);
    if (grid_reg[a] < 5'd1) return 1;
    if (grid_reg[a] > 5'd16) return 16;
    return grid_reg[a];
  endfunction

  // Sum of the counts of all cells below limit
  function automatic int unsigned count_below(input int unsigned limit);
    int unsigned total;
    total = 0;
    for (int i = 0; i < NCELL_MAX && i < limit; i++) total += occ_count[i];
    return total;
  endfunction

  // Result beat for one input beat; updates the shadow counts
  function automatic res_t cell_outcome(input logic [1:0] op, input logic present,
                                        input logic [31:0] handle,
                                        input logic [23:0] px, input logic [23:0] py,
                                        input logic [23:0] pz, input logic [11:0] qcell);
    res_t        r;
    logic [23:0] pos [3];
    logic [63:0] prod;
    int unsigned lim [3];
    int unsigned coord [3];
    int unsigned lin, cnt, slots, ncell;
    bit          outside;
    r = '0;
    slots = (slots_reg < 6'd1) ? 1 : (slots_reg > NSLOT_MAX) ? NSLOT_MAX : slots_reg;
    for (int a = 0; a < 3; a++) lim[a] = axis_cells(a);
    ncell = lim[0] * lim[1] * lim[2];
    if (ncell > NCELL_MAX) ncell = NCELL_MAX;
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < NCELL_MAX; i++) occ_count[i] = '0;
      end
      OP_BIN: begin
        r.handle_out = handle;
        if (!present) begin
          r.status = ST_ABSENT;
        end else begin
          pos[0] = px;
          pos[1] = py;
          pos[2] = pz;
          outside = 1'b0;
          // floor(pos * inv): Q8.16 times Q8.16 gives Q16.32
          for (int a = 0; a < 3; a++) begin
            prod = 64'(pos[a]) * 64'(inv_reg[a]);
            if ((prod >> 32) >= 64'(lim[a])) outside = 1'b1;
            coord[a] = prod[47:32];
          end
          lin = 0;
          if (!outside) begin
            lin = coord[0] + lim[0] * (coord[1] + lim[1] * coord[2]);
            if (lin >= NCELL_MAX) outside = 1'b1;
          end
          if (outside) begin
            r.status = ST_OUTSIDE;
          end else begin
            cnt = occ_count[lin];
            r.cell_index = lin[11:0];
            if (cnt >= slots) begin
              r.status     = ST_FULL;
              r.cell_count = cnt[5:0];
            end else begin
              r.write_slot   = 17'(lin * slots + cnt);
              occ_count[lin] = 6'(cnt + 1);
              r.cell_count   = 6'(cnt + 1);
            end
          end
        end
      end
      OP_QUERY: begin
        r.cell_index = qcell;
        if (qcell >= ncell) begin
          r.status     = ST_OUTSIDE;
          r.cell_start = 18'(count_below(ncell));
        end else begin
          r.cell_count = occ_count[qcell];
          r.cell_start = 18'(count_below(qcell));
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Channel monitor: compare result beats, predict input beats, track setup
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCELL_MAX; i++) occ_count[i] = '0;
      for (int a = 0; a < 3; a++) begin
        grid_reg[a] = CELLS_RST;
        inv_reg[a]  = INV_RST;
      end
      slots_reg = SLOTS_RST;
      outcome_q.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (outcome_q.size() == 0) begin
          $error("result beat with no outstanding request");
          mismatches++;
        end else begin
          head = outcome_q.pop_front();
          check_field("status", head.status, out_status);
          check_field("cell_index", head.cell_index, out_cell_index);
          check_field("write_slot", head.write_slot, out_write_slot);
          check_field("handle_out", head.handle_out, out_handle_out);
          check_field("cell_count", head.cell_count, out_cell_count);
          check_field("cell_start", head.cell_start, out_cell_start);
        end
      end
      if (in_push && !in_full)
        outcome_q.push_back(cell_outcome(in_op, in_exists, in_handle, in_pos_x,
                                         in_pos_y, in_pos_z, in_query_cell));
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_reg_t'(cfg_paddr[CFG_AW-1:2]))
          REG_CELLS_X: grid_reg[0] = cfg_pwdata[4:0];
          REG_CELLS_Y: grid_reg[1] = cfg_pwdata[4:0];
          REG_CELLS_Z: grid_reg[2] = cfg_pwdata[4:0];
          REG_INV_X:   inv_reg[0]  = cfg_pwdata[23:0];
          REG_INV_Y:   inv_reg[1]  = cfg_pwdata[23:0];
          REG_INV_Z:   inv_reg[2]  = cfg_pwdata[23:0];
          REG_SLOTS:   slots_reg   = cfg_pwdata[5:0];
          default: begin
          end
        endcase
      end
      outstanding = outcome_q.size();
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the particle cell binning block
// Drives a directed opening and then random phases of bin, query, clear and
// unused-op beats under several grid setups, with random idling on both
// channels, a long receiver hold-off and a drain pause. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  import pcb_pkg::*;

  localparam int         TIMEOUT_CYCLES = 2_000_000;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         SETTLE_CYCLES  = 16;
  localparam int         TAIL_CYCLES    = 50;
  localparam int         N_PHASES       = 8;
  localparam int         PHASE_ITEMS    = 125;
  localparam logic [1:0] OP_UNUSED      = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  logic [1:0]          in_op;
  logic                in_exists;
  logic [31:0]         in_handle;
  logic [23:0]         in_pos_x;
  logic [23:0]         in_pos_y;
  logic [23:0]         in_pos_z;
  logic [11:0]         in_query_cell;
  logic                out_empty;
  logic                out_pop;
  logic [1:0]          out_status;
  logic [11:0]         out_cell_index;
  logic [16:0]         out_write_slot;
  logic [31:0]         out_handle_out;
  logic [5:0]          out_cell_count;
  logic [17:0]         out_cell_start;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  int          mismatches;
  int          outstanding;
  int          cycle_count;
  int          tx_idle = 29;
  int          rx_idle = 73;
  bit          hold_req;
  // stimulus-side view of the grid, used to aim coordinates and query cells
  int          eff_cells [3];
  logic [23:0] inv_v [3];
  int          grid_total;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  particle_cell_binning i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_op          (in_op),
    .in_exists      (in_exists),
    .in_handle      (in_handle),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_query_cell  (in_query_cell),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_status     (out_status),
    .out_cell_index (out_cell_index),
    .out_write_slot (out_write_slot),
    .out_handle_out (out_handle_out),
    .out_cell_count (out_cell_count),
    .out_cell_start (out_cell_start),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  pcb_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_op          (in_op),
    .in_exists      (in_exists),
    .in_handle      (in_handle),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_query_cell  (in_query_cell),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_status     (out_status),
    .out_cell_index (out_cell_index),
    .out_write_slot (out_write_slot),
    .out_handle_out (out_handle_out),
    .out_cell_count (out_cell_count),
    .out_cell_start (out_cell_start),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < TIMEOUT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Result side: random pops, with a long hold-off on request
  initial begin
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_pop <= ($urandom_range(99) >= rx_idle);
    end
  end

  // One input beat, after a random gap; returns at the accepting edge
  task automatic push_item(input logic [1:0] op, input logic present,
                           input logic [31:0] handle, input logic [23:0] px,
                           input logic [23:0] py, input logic [23:0] pz,
                           input logic [11:0] qcell);
    int gap;
    gap = 0;
    while (tx_idle > 0 && $urandom_range(99) < tx_idle) gap++;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_op         <= op;
    in_exists     <= present;
    in_handle     <= handle;
    in_pos_x      <= px;
    in_pos_y      <= py;
    in_pos_z      <= pz;
    in_query_cell <= qcell;
    in_push       <= 1'b1;
    do @(posedge clk); while (in_full);
  endtask

  // Stop offering and wait until every predicted beat has been returned
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup beat, then access beat until pready
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_grid(input logic [4:0] cx, input logic [4:0] cy,
                              input logic [4:0] cz, input logic [23:0] ix,
                              input logic [23:0] iy, input logic [23:0] iz,
                              input logic [5:0] slots);
    logic [4:0] raw [3];
    write_reg(REG_CELLS_X, 32'(cx));
    write_reg(REG_CELLS_Y, 32'(cy));
    write_reg(REG_CELLS_Z, 32'(cz));
    write_reg(REG_INV_X, 32'(ix));
    write_reg(REG_INV_Y, 32'(iy));
    write_reg(REG_INV_Z, 32'(iz));
    write_reg(REG_SLOTS, 32'(slots));
    raw[0] = cx;
    raw[1] = cy;
    raw[2] = cz;
    inv_v[0] = ix;
    inv_v[1] = iy;
    inv_v[2] = iz;
    for (int a = 0; a < 3; a++)
      eff_cells[a] = (raw[a] == 5'd0) ? 1 : (raw[a] > 5'd16) ? 16 : raw[a];
    grid_total = eff_cells[0] * eff_cells[1] * eff_cells[2];
  endtask

  // Inverse cell length: mostly unit or power of two, sometimes random or extreme
  function automatic logic [23:0] pick_inv();
    case ($urandom_range(9))
      0:       return 24'd0;
      1:       return 24'hFF_FFFF;
      2, 3:    return 24'($urandom);
      4, 5:    return 24'(1 << $urandom_range(10, 23));
      default: return 24'd65536;
    endcase
  endfunction

  function automatic logic [4:0] pick_cells();
    if ($urandom_range(9) == 0) return 5'($urandom_range(31));
    return 5'($urandom_range(1, 6));
  endfunction

  // Coordinate aimed into a chosen cell, now and then just past the edge
  function automatic logic [23:0] aim_pos(input int a);
    logic [63:0] num;
    int          target;
    if (inv_v[a] == 24'd0) return 24'($urandom);
    target = ($urandom_range(19) == 0) ? eff_cells[a] : $urandom_range(eff_cells[a] - 1);
    num = ((64'(target)) << 32) + 64'($urandom);
    num = num / 64'(inv_v[a]);
    if (num > 64'h00FF_FFFF) return 24'($urandom);
    return num[23:0];
  endfunction

  task automatic send_random_item();
    int          sel;
    int          qtop;
    bit          present;
    bit          raw;
    logic [11:0] qcell;
    logic [23:0] p [3];
    sel     = $urandom_range(99);
    present = ($urandom_range(19) != 0);
    raw     = ($urandom_range(7) == 0);
    qtop    = (grid_total + 1 > 4095) ? 4095 : grid_total + 1;
    qcell   = ($urandom_range(4) == 0) ? 12'($urandom_range(4095)) : 12'($urandom_range(qtop));
    for (int a = 0; a < 3; a++) p[a] = raw ? 24'($urandom) : aim_pos(a);
    if (sel < 2)
      push_item(OP_CLEAR, present, $urandom, p[0], p[1], p[2], qcell);
    else if (sel < 3)
      push_item(OP_UNUSED, present, $urandom, p[0], p[1], p[2], qcell);
    else if (sel < 25)
      push_item(OP_QUERY, present, $urandom, p[0], p[1], p[2], qcell);
    else
      push_item(OP_BIN, present, $urandom, p[0], p[1], p[2], qcell);
  endtask

  // Reset, directed opening, random phases, verdict
  initial begin
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_op         = OP_CLEAR;
    in_exists     = 1'b0;
    in_handle     = '0;
    in_pos_x      = '0;
    in_pos_y      = '0;
    in_pos_z      = '0;
    in_query_cell = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    hold_req      = 1'b0;
    for (int a = 0; a < 3; a++) begin
      eff_cells[a] = 1;
      inv_v[a]     = INV_RST;
    end
    grid_total = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset setup: one cell of unit length
    push_item(OP_QUERY, 1'b0, 32'h0, 24'h0, 24'h0, 24'h0, 12'd0);
    push_item(OP_BIN, 1'b0, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 12'hFFF);
    push_item(OP_BIN, 1'b1, 32'h0, 24'h0, 24'h0, 24'h0, 12'd0);
    push_item(OP_BIN, 1'b1, 32'h1234_5678, 24'h00_FFFF, 24'h00_FFFF, 24'h00_FFFF, 12'd0);
    push_item(OP_BIN, 1'b1, 32'hA5A5_A5A5, 24'h01_0000, 24'h0, 24'h0, 12'd0);
    push_item(OP_BIN, 1'b1, 32'h5A5A_5A5A, 24'h0, 24'hFF_FFFF, 24'h0, 12'd0);
    push_item(OP_BIN, 1'b1, 32'hFFFF_FFFF, 24'h0, 24'h0, 24'hFF_FFFF, 12'd0);
    push_item(OP_QUERY, 1'b0, 32'h0, 24'h0, 24'h0, 24'h0, 12'd0);
    push_item(OP_QUERY, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 12'd1);
    push_item(OP_QUERY, 1'b0, 32'h0, 24'h0, 24'h0, 24'h0, 12'hFFF);
    push_item(OP_UNUSED, 1'b1, 32'hDEAD_BEEF, 24'h12_3456, 24'h65_4321, 24'hAB_CDEF, 12'hABC);
    push_item(OP_CLEAR, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 12'hFFF);
    push_item(OP_QUERY, 1'b0, 32'h0, 24'h0, 24'h0, 24'h0, 12'd0);

    // directed, clamped registers: 16 x 1 x 16 grid, one slot per cell
    settle();
    program_grid(5'd31, 5'd0, 5'd16, 24'hFF_FFFF, 24'd0, 24'd65536, 6'd0);
    push_item(OP_BIN, 1'b1, 32'h0000_0001, 24'h0, 24'hFF_FFFF, 24'h0, 12'd0);
    push_item(OP_BIN, 1'b1, 32'h0000_0002, 24'h0, 24'hFF_FFFF, 24'h0, 12'd0);
    push_item(OP_BIN, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'h0, 24'h0, 12'd0);
    push_item(OP_BIN, 1'b1, 32'h8000_0000, 24'h00_0F10, 24'h0, 24'h0F_8000, 12'd0);
    push_item(OP_QUERY, 1'b0, 32'h0, 24'h0, 24'h0, 24'h0, 12'd255);
    push_item(OP_QUERY, 1'b0, 32'h0, 24'h0, 24'h0, 24'h0, 12'd256);
    push_item(OP_QUERY, 1'b0, 32'h0, 24'h0, 24'h0, 24'h0, 12'd0);

    // random phases, each under a fresh setup
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      if (ph < 3) begin
        tx_idle = 29;
        rx_idle = 73;
      end else if (ph < 6) begin
        tx_idle = 73;
        rx_idle = 29;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      if (ph == 1)
        program_grid(5'd1, 5'd1, 5'd1, pick_inv(), pick_inv(), pick_inv(),
                     6'($urandom_range(1, 2)));
      else if (ph == 3)
        program_grid(5'd16, 5'd16, 5'd16, pick_inv(), pick_inv(), pick_inv(), 6'd63);
      else
        program_grid(pick_cells(), pick_cells(), pick_cells(), pick_inv(), pick_inv(),
                     pick_inv(),
                     ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                              : 6'($urandom_range(1, 4)));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // back-pressure: long receiver stall, later a full drain
        if (ph == 6 && i == 30) hold_req = 1'b1;
        if (ph == 6 && i == 90) settle();
        send_random_item();
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
